// File: rtl/core/fbpa_pkg.sv
package fbpa_pkg;

  localparam int DATA_W  = 32;
  localparam int BYTES_W = 16;
  localparam int CNT_W   = 11;
  localparam int SPAN_W  = BYTES_W + CNT_W;
  localparam int STEP_W  = $clog2(CNT_W);
  localparam int ST_W    = 3;
  localparam int FUNC_W  = 2;
  localparam int PADDR_W = 4;

  localparam int MAX_BLOCKS_DEF = 1024;
  localparam int ADDR_WIDTH_DEF = 32;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(2047);

  localparam logic [DATA_W-1:0]  POOL_BASE_RST   = 32'd4096;
  localparam logic [BYTES_W-1:0] BLOCK_BYTES_RST = 16'd64;
  localparam logic [CNT_W-1:0]   BLOCK_COUNT_RST = 11'd1024;

  localparam logic [1:0] REG_POOL_BASE   = 2'd0;
  localparam logic [1:0] REG_BLOCK_BYTES = 2'd1;
  localparam logic [1:0] REG_BLOCK_COUNT = 2'd2;

  localparam logic [FUNC_W-1:0] FN_ALLOC   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_FREE    = 2'd1;
  localparam logic [FUNC_W-1:0] FN_RESTART = 2'd2;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_EXHAUSTED = 3'd1;
  localparam logic [ST_W-1:0] ST_NULL      = 3'd2;
  localparam logic [ST_W-1:0] ST_INVALID   = 3'd3;
  localparam logic [ST_W-1:0] ST_OVERFLOW  = 3'd4;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [DATA_W-1:0] release_address;
  } in_t;

  typedef struct packed {
    logic [DATA_W-1:0] block_address;
    logic [ST_W-1:0]   status;
    logic [CNT_W-1:0]  in_use;
    logic [CNT_W-1:0]  peak_in_use;
    logic [DATA_W-1:0] total_allocations;
    logic [DATA_W-1:0] total_releases;
  } out_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_POP  = 8'b0000_0010,
    S_MUL  = 8'b0000_0100,
    S_ADD  = 8'b0000_1000,
    S_BASE = 8'b0001_0000,
    S_SPAN = 8'b0010_0000,
    S_DIV  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

endpackage

// File: rtl/core/fbpa_alu.sv
module fbpa_alu
  import fbpa_pkg::*;
#(
  parameter int WIDTH = 33
) (
  input  alu_op_t          op,
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  output logic [WIDTH-1:0] y,
  output logic             borrow
);

  logic [WIDTH-1:0] b_eff;
  logic [WIDTH:0]   sum;

  assign b_eff  = (op == ALU_SUB) ? ~b : b;
  assign sum    = {1'b0, a} + {1'b0, b_eff} + {{WIDTH{1'b0}}, (op == ALU_SUB)};
  assign y      = sum[WIDTH-1:0];
  assign borrow = (op == ALU_SUB) && !sum[WIDTH];

endmodule

// File: rtl/core/fbpa_stack.sv
module fbpa_stack
  import fbpa_pkg::*;
#(
  parameter int DEPTH = MAX_BLOCKS_DEF,
  parameter int WIDTH = ADDR_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_idx,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_idx,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] stack_mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= stack_mem[rd_idx];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/fixed_block_pool_allocator.sv
// Request paths through the states: restart, null free, unused code or exhausted pool go
// straight to S_DONE; a recycled allocate passes S_POP; a fresh allocate S_MUL and S_ADD; a free
// below base S_MUL and S_BASE; a free past the pool end adds S_SPAN; a free that passes that also
// runs the eleven-pass alignment check in S_DIV. One transaction at a time: the next is accepted
// in the cycle after the result is registered, and S_DONE waits while the previous result stalls.
// Synchronous active-low reset restores register defaults and clears counters, not the stack.
module fixed_block_pool_allocator
  import fbpa_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_t                in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_t               out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  localparam int IW  = $clog2(MAX_BLOCKS);
  localparam int TW  = $clog2(MAX_BLOCKS + 1);
  localparam int ALW = (ADDR_WIDTH > SPAN_W) ? ADDR_WIDTH : SPAN_W;
  localparam int FRESH_RST_I = (int'(BLOCK_COUNT_RST) > MAX_BLOCKS) ? MAX_BLOCKS
                                                                     : int'(BLOCK_COUNT_RST);
  localparam logic [CNT_W-1:0] FRESH_RST = CNT_W'(FRESH_RST_I);

  state_t state_r, state_nxt;

  logic [DATA_W-1:0]     pool_base_r;
  logic [BYTES_W-1:0]    block_bytes_r;
  logic [CNT_W-1:0]      block_count_r;

  logic [FUNC_W-1:0]     func_r, func_nxt;
  logic [ADDR_WIDTH-1:0] addr_r, addr_nxt;
  logic [ADDR_WIDTH-1:0] res_addr_r, res_addr_nxt;
  logic [ST_W-1:0]       status_r, status_nxt;
  logic                  alloc_ok_r, alloc_ok_nxt;
  logic                  free_ok_r, free_ok_nxt;
  logic                  restart_r, restart_nxt;
  logic                  from_stack_r, from_stack_nxt;
  logic [SPAN_W-1:0]     prod_r, prod_nxt;
  logic [ALW-1:0]        rem_r, rem_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;

  logic [TW-1:0]         top_r, top_nxt;
  logic [CNT_W-1:0]      fresh_r, fresh_nxt;
  logic [CNT_W-1:0]      used_r, used_nxt;
  logic [CNT_W-1:0]      peak_r, peak_nxt;
  logic [DATA_W-1:0]     alloc_total_r, alloc_total_nxt;
  logic [DATA_W-1:0]     free_total_r, free_total_nxt;

  logic                  out_valid_r, out_valid_nxt;
  out_t                  out_data_r, out_data_nxt;
  logic                  out_load;

  logic [CNT_W-1:0]      cnt_clamped;
  logic [CNT_W-1:0]      mul_b;
  logic [SPAN_W-1:0]     mul_y;
  logic [ADDR_WIDTH-1:0] base_aw;
  logic [ADDR_WIDTH-1:0] in_addr_aw;
  logic [TW-1:0]         top_dec;
  logic [ALW-1:0]        rem_new;

  alu_op_t               alu_op;
  logic [ALW-1:0]        alu_a, alu_b, alu_y;
  logic                  alu_borrow;

  logic                  stk_wr, stk_rd;
  logic [ADDR_WIDTH-1:0] stk_rd_data;

  logic                  cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r   <= POOL_BASE_RST;
      block_bytes_r <= BLOCK_BYTES_RST;
      block_count_r <= BLOCK_COUNT_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_POOL_BASE:   pool_base_r   <= pwdata;
        REG_BLOCK_BYTES: block_bytes_r <= pwdata[BYTES_W-1:0];
        REG_BLOCK_COUNT: block_count_r <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_POOL_BASE:   prdata = pool_base_r;
      REG_BLOCK_BYTES: prdata = DATA_W'(block_bytes_r);
      REG_BLOCK_COUNT: prdata = DATA_W'(block_count_r);
      default:         prdata = '0;
    endcase
  end

  assign cnt_clamped = (32'(block_count_r) > 32'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                              : block_count_r;
  assign mul_y       = SPAN_W'(block_bytes_r) * SPAN_W'(mul_b);
  assign base_aw     = ADDR_WIDTH'(pool_base_r);
  assign in_addr_aw  = ADDR_WIDTH'(in_data.release_address);
  assign top_dec     = top_r - TW'(1);
  assign rem_new     = alu_borrow ? rem_r : alu_y;

  fbpa_alu #(
    .WIDTH (ALW)
  ) u_alu (
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .y      (alu_y),
    .borrow (alu_borrow)
  );

  fbpa_stack #(
    .DEPTH (MAX_BLOCKS),
    .WIDTH (ADDR_WIDTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (stk_wr),
    .wr_idx  (top_r[IW-1:0]),
    .wr_data (addr_r),
    .rd_en   (stk_rd),
    .rd_idx  (top_dec[IW-1:0]),
    .rd_data (stk_rd_data)
  );

  always_comb begin
    state_nxt       = state_r;
    func_nxt        = func_r;
    addr_nxt        = addr_r;
    res_addr_nxt    = res_addr_r;
    status_nxt      = status_r;
    alloc_ok_nxt    = alloc_ok_r;
    free_ok_nxt     = free_ok_r;
    restart_nxt     = restart_r;
    from_stack_nxt  = from_stack_r;
    prod_nxt        = prod_r;
    rem_nxt         = rem_r;
    step_nxt        = step_r;
    top_nxt         = top_r;
    fresh_nxt       = fresh_r;
    used_nxt        = used_r;
    peak_nxt        = peak_r;
    alloc_total_nxt = alloc_total_r;
    free_total_nxt  = free_total_r;
    out_load        = 1'b0;
    stk_wr          = 1'b0;
    stk_rd          = 1'b0;
    mul_b           = cnt_clamped;
    alu_op          = ALU_SUB;
    alu_a           = rem_r;
    alu_b           = ALW'(block_bytes_r) << step_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt       = in_data.func;
          addr_nxt       = in_addr_aw;
          res_addr_nxt   = '0;
          status_nxt     = ST_OK;
          alloc_ok_nxt   = 1'b0;
          free_ok_nxt    = 1'b0;
          restart_nxt    = 1'b0;
          from_stack_nxt = 1'b0;
          case (in_data.func)
            FN_ALLOC: begin
              if (top_r != '0) begin
                state_nxt = S_POP;
              end else if (fresh_r != '0) begin
                fresh_nxt = fresh_r - CNT_W'(1);
                state_nxt = S_MUL;
              end else begin
                status_nxt = ST_EXHAUSTED;
                state_nxt  = S_DONE;
              end
            end
            FN_FREE: begin
              if (in_addr_aw == '0) begin
                status_nxt = ST_NULL;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_MUL;
              end
            end
            FN_RESTART: begin
              restart_nxt = 1'b1;
              state_nxt   = S_DONE;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_POP: begin
        stk_rd         = 1'b1;
        top_nxt        = top_dec;
        from_stack_nxt = 1'b1;
        alloc_ok_nxt   = 1'b1;
        state_nxt      = S_DONE;
      end
      S_MUL: begin
        mul_b     = (func_r == FN_ALLOC) ? fresh_r : cnt_clamped;
        prod_nxt  = mul_y;
        state_nxt = (func_r == FN_ALLOC) ? S_ADD : S_BASE;
      end
      S_ADD: begin
        alu_op       = ALU_ADD;
        alu_a        = ALW'(base_aw);
        alu_b        = ALW'(prod_r);
        res_addr_nxt = ADDR_WIDTH'(alu_y);
        alloc_ok_nxt = 1'b1;
        state_nxt    = S_DONE;
      end
      S_BASE: begin
        alu_a = ALW'(addr_r);
        alu_b = ALW'(base_aw);
        if (alu_borrow) begin
          status_nxt = ST_INVALID;
          state_nxt  = S_DONE;
        end else begin
          rem_nxt   = alu_y;
          state_nxt = S_SPAN;
        end
      end
      S_SPAN: begin
        alu_b = ALW'(prod_r);
        if (!alu_borrow) begin
          status_nxt = ST_INVALID;
          state_nxt  = S_DONE;
        end else begin
          step_nxt  = STEP_W'(CNT_W - 1);
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt = rem_new;
        if (step_r == '0) begin
          if (rem_new != '0) begin
            status_nxt = ST_INVALID;
          end else if (32'(top_r) >= 32'(MAX_BLOCKS)) begin
            status_nxt = ST_OVERFLOW;
          end else begin
            free_ok_nxt = 1'b1;
          end
          state_nxt = S_DONE;
        end else begin
          step_nxt = step_r - STEP_W'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
          if (alloc_ok_r) begin
            alloc_total_nxt = alloc_total_r + DATA_W'(1);
            if (used_r < CNT_MAX) begin
              used_nxt = used_r + CNT_W'(1);
            end
          end
          if (free_ok_r) begin
            stk_wr         = 1'b1;
            top_nxt        = top_r + TW'(1);
            free_total_nxt = free_total_r + DATA_W'(1);
            if (used_r != '0) begin
              used_nxt = used_r - CNT_W'(1);
            end
          end
          if (used_nxt > peak_r) begin
            peak_nxt = used_nxt;
          end
          if (restart_r) begin
            top_nxt         = '0;
            fresh_nxt       = cnt_clamped;
            used_nxt        = '0;
            peak_nxt        = '0;
            alloc_total_nxt = '0;
            free_total_nxt  = '0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_data_nxt.block_address     = from_stack_r ? DATA_W'(stk_rd_data) : DATA_W'(res_addr_r);
    out_data_nxt.status            = status_r;
    out_data_nxt.in_use            = used_nxt;
    out_data_nxt.peak_in_use       = peak_nxt;
    out_data_nxt.total_allocations = alloc_total_nxt;
    out_data_nxt.total_releases    = free_total_nxt;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      top_r         <= '0;
      fresh_r       <= FRESH_RST;
      used_r        <= '0;
      peak_r        <= '0;
      alloc_total_r <= '0;
      free_total_r  <= '0;
      out_valid_r   <= 1'b0;
      alloc_ok_r    <= 1'b0;
      free_ok_r     <= 1'b0;
      restart_r     <= 1'b0;
      from_stack_r  <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      top_r         <= top_nxt;
      fresh_r       <= fresh_nxt;
      used_r        <= used_nxt;
      peak_r        <= peak_nxt;
      alloc_total_r <= alloc_total_nxt;
      free_total_r  <= free_total_nxt;
      out_valid_r   <= out_valid_nxt;
      alloc_ok_r    <= alloc_ok_nxt;
      free_ok_r     <= free_ok_nxt;
      restart_r     <= restart_nxt;
      from_stack_r  <= from_stack_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    addr_r     <= addr_nxt;
    res_addr_r <= res_addr_nxt;
    status_r   <= status_nxt;
    prod_r     <= prod_nxt;
    rem_r      <= rem_nxt;
    step_r     <= step_nxt;
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/core/fbpa_checker.sv
module fbpa_checker
  import fbpa_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled result changed or was dropped.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("Block took a second transaction before finishing the first.");

  a_addr_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |-> (out_data.block_address == '0))
    else $error("Rejected request returned a nonzero block address.");

  a_peak_bounds_use: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.peak_in_use >= out_data.in_use))
    else $error("Peak usage fell below current usage.");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
